// ===== rtl/priority_interrupt_controller_regs_core_defines.svh =====
// Assertion macros for the file that checks its own logic.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PRIORITY_INTERRUPT_CONTROLLER_REGS_CORE_DEFINES_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_REGS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pic_regs_pkg.sv =====
package pic_regs_pkg;

  localparam int NUM_SOURCES = 15;
  localparam int SRC_IDX_W   = $clog2(NUM_SOURCES);
  localparam int LVL_W       = 3;
  localparam int ADDR_W      = 13;
  localparam int DATA_W      = 8;
  localparam int MASK_W      = 15;
  localparam int PEND_OUT_W  = 15;
  localparam int CNT_W       = 64;

  // The 60Hz source.
  localparam int SRC_60HZ = 10;

  localparam logic [ADDR_W-1:0] OFF_STAT0  = 13'h200;
  localparam logic [ADDR_W-1:0] OFF_ROMCTL = 13'h204;
  localparam logic [ADDR_W-1:0] OFF_CNTCTL = 13'h205;
  localparam logic [ADDR_W-1:0] OFF_ACK60  = 13'h207;
  localparam logic [ADDR_W-1:0] OFF_COUNT  = 13'h208;

  localparam logic [DATA_W-1:0] ROM_CTL_RST = 8'h0d;

  // Reset levels, source 14 in the leftmost slot.
  localparam logic [14:0][LVL_W-1:0] LVL_RST_TAB = {
    3'd7, 3'd1, 3'd3, 3'd1, 3'd0, 3'd2, 3'd2, 3'd4,
    3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
  };

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_SET   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef logic [NUM_SOURCES-1:0][LVL_W-1:0] lvl_arr_t;

  typedef struct packed {
    mode_t               mode;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   write_data;
    logic [MASK_W-1:0]   source_mask;
  } pic_req_t;

  typedef struct packed {
    lvl_arr_t               levels;
    logic [NUM_SOURCES-1:0] pending;
    logic [DATA_W-1:0]      rom_ctl;
    logic [DATA_W-1:0]      cnt_ctl;
    logic [CNT_W-1:0]       counter;
  } pic_state_t;

  typedef struct packed {
    logic [DATA_W-1:0]     read_data;
    logic                  irq_notify;
    logic                  control_strobe;
    logic [DATA_W-1:0]     control_value;
    logic [PEND_OUT_W-1:0] pending_sources;
    logic [LVL_W-1:0]      highest_level;
  } pic_res_t;

  localparam pic_state_t ST_RST = '{
    levels:  LVL_RST_TAB[NUM_SOURCES-1:0],
    pending: '0,
    rom_ctl: ROM_CTL_RST,
    cnt_ctl: '0,
    counter: '0
  };

endpackage

// ===== rtl/pic_regs_exec.sv =====
// Executes one request against the current register state and forms the
// next state together with the result of the request.
module pic_regs_exec (
  input  pic_regs_pkg::pic_req_t   req,
  input  pic_regs_pkg::pic_state_t st,
  output pic_regs_pkg::pic_state_t st_nxt,
  output pic_regs_pkg::pic_res_t   res
);
  import pic_regs_pkg::*;

  logic                   is_lvl;
  logic                   is_stat;
  logic                   is_cnt;
  logic [1:0]             lane;
  logic [2:0]             cidx;
  logic [31:0]            pend32;
  logic [NUM_SOURCES-1:0] lane_clr;
  logic [LVL_W-1:0]       lvl_sel;
  logic [DATA_W-1:0]      rd;
  logic                   strobe;
  logic                   force_notify;
  logic [(1<<LVL_W)-1:0]  lvl_hit;
  logic [LVL_W-1:0]       top_lvl;

  assign is_lvl   = req.address < ADDR_W'(NUM_SOURCES);
  assign is_stat  = req.address[ADDR_W-1:2] == OFF_STAT0[ADDR_W-1:2];
  assign is_cnt   = req.address[ADDR_W-1:3] == OFF_COUNT[ADDR_W-1:3];
  assign lane     = req.address[1:0];
  assign cidx     = req.address[2:0];
  assign pend32   = 32'(st.pending);
  // The pending word is big-endian, so lane k covers bits (3-k)*8 and up.
  assign lane_clr = NUM_SOURCES'(32'(req.write_data) << {~lane, 3'b000});

  always_comb begin
    lvl_sel = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (req.address == ADDR_W'(i)) begin
        lvl_sel = st.levels[i];
      end
    end
  end

  always_comb begin
    st_nxt       = st;
    rd           = '0;
    strobe       = 1'b0;
    force_notify = 1'b0;
    unique case (req.mode)
      MODE_READ: begin
        if (is_lvl) begin
          rd = DATA_W'(lvl_sel);
        end else if (is_stat) begin
          rd = DATA_W'(pend32 >> {~lane, 3'b000});
        end else if (req.address == OFF_ROMCTL) begin
          rd = st.rom_ctl;
        end else if (req.address == OFF_CNTCTL) begin
          rd = st.cnt_ctl;
        end else if (req.address == OFF_ACK60) begin
          st_nxt.pending[SRC_60HZ] = 1'b0;
        end else if (is_cnt) begin
          rd = DATA_W'(st.counter >> {~cidx, 3'b000});
          if (!st.cnt_ctl[0]) begin
            st_nxt.counter = st.counter + CNT_W'(1);
          end
        end
      end
      MODE_WRITE: begin
        if (is_lvl) begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (req.address == ADDR_W'(i)) begin
              st_nxt.levels[i] = req.write_data[LVL_W-1:0];
            end
          end
          if (req.address == ADDR_W'(SRC_60HZ)) begin
            st_nxt.pending[SRC_60HZ] = |req.write_data[LVL_W-1:0];
          end else begin
            force_notify = 1'b1;
          end
        end else if (is_stat) begin
          st_nxt.pending = st.pending & ~lane_clr;
        end else if (req.address == OFF_ROMCTL) begin
          st_nxt.rom_ctl = req.write_data;
          strobe         = 1'b1;
          force_notify   = 1'b1;
        end else if (req.address == OFF_CNTCTL) begin
          st_nxt.cnt_ctl = req.write_data;
        end else if (req.address == OFF_ACK60) begin
          st_nxt.pending[SRC_60HZ] = 1'b0;
        end
      end
      MODE_SET: begin
        st_nxt.pending = st.pending | req.source_mask[NUM_SOURCES-1:0];
      end
      MODE_CLEAR: begin
        st_nxt.pending = st.pending & ~req.source_mask[NUM_SOURCES-1:0];
      end
    endcase
  end

  // One flag per level value: some pending source sits at that level.
  always_comb begin
    lvl_hit = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (st_nxt.pending[i]) begin
        lvl_hit[st_nxt.levels[i]] = 1'b1;
      end
    end
  end

  always_comb begin
    top_lvl = '0;
    for (int l = 1; l < (1 << LVL_W); l++) begin
      if (lvl_hit[l]) begin
        top_lvl = LVL_W'(l);
      end
    end
  end

  assign res.read_data       = rd;
  assign res.irq_notify      = force_notify || (st_nxt.pending != st.pending);
  assign res.control_strobe  = strobe;
  assign res.control_value   = st_nxt.rom_ctl;
  assign res.pending_sources = PEND_OUT_W'(st_nxt.pending);
  assign res.highest_level   = top_lvl;

endmodule

// ===== rtl/priority_interrupt_controller_regs_core.sv =====
//  Channel  Ports                                   Direction  Handshake
//  -------  --------------------------------------  ---------  --------------------
//  in       in_mode/address/write_data/source_mask  input      in_valid, in_stall
//  out      out_read_data ... out_highest_level     output     out_valid, out_stall
//
//  A request is captured in the input register and executes as it moves into the
//  result register, once that register is empty or being drained.
//  One request is accepted per clock while results are taken; throughput is set
//  by the single execute step between the two registers.
//  Reset is synchronous and active low and restores the power-on register values.
//  A result-side stall holds both registers and raises in_stall once both are full.
`include "priority_interrupt_controller_regs_core_defines.svh"

module priority_interrupt_controller_regs_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_mode,
  input  logic [pic_regs_pkg::ADDR_W-1:0]       in_address,
  input  logic [pic_regs_pkg::DATA_W-1:0]       in_write_data,
  input  logic [pic_regs_pkg::MASK_W-1:0]       in_source_mask,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [pic_regs_pkg::DATA_W-1:0]       out_read_data,
  output logic                                  out_irq_notify,
  output logic                                  out_control_strobe,
  output logic [pic_regs_pkg::DATA_W-1:0]       out_control_value,
  output logic [pic_regs_pkg::PEND_OUT_W-1:0]   out_pending_sources,
  output logic [pic_regs_pkg::LVL_W-1:0]        out_highest_level
);
  import pic_regs_pkg::*;

  // Input register: holds one accepted request until it can execute.
  logic       inq_valid_r, inq_valid_nxt;
  pic_req_t   inq_r;
  // Result register: holds the finished result until the consumer takes it.
  logic       out_valid_r, out_valid_nxt;
  pic_res_t   out_r;
  // Architectural register state of the controller.
  pic_state_t st_r;
  pic_state_t st_nxt;
  pic_res_t   res;

  logic       in_acc;
  logic       adv;

  // A request executes when the result register is empty or being drained.
  // State and result are committed together on that edge, which keeps the
  // requests in order with no hazard between back-to-back items.
  assign adv      = inq_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = inq_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    inq_valid_nxt = inq_valid_r;
    if (in_acc) begin
      inq_valid_nxt = 1'b1;
    end else if (adv) begin
      inq_valid_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  pic_regs_exec u_exec (
    .req    (inq_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= ST_RST;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers need no reset; they are qualified by the valid flags.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      inq_r.mode        <= mode_t'(in_mode);
      inq_r.address     <= in_address;
      inq_r.write_data  <= in_write_data;
      inq_r.source_mask <= in_source_mask;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_r.read_data;
  assign out_irq_notify      = out_r.irq_notify;
  assign out_control_strobe  = out_r.control_strobe;
  assign out_control_value   = out_r.control_value;
  assign out_pending_sources = out_r.pending_sources;
  assign out_highest_level   = out_r.highest_level;

  // A ROM-control write always raises the notify flag with its strobe.
  `PIC_ASSERT_NOW(a_strobe_notify, out_valid_r && out_r.control_strobe, out_r.irq_notify, "strobe without notify")
  // No pending source means no active level.
  `PIC_ASSERT_NOW(a_idle_level, out_valid_r && (out_r.pending_sources == '0), out_r.highest_level == '0, "level with nothing pending")
  // The register state moves only when a request executes.
  `PIC_ASSERT_NEXT(a_state_hold, !adv, st_r == $past(st_r), "state changed without a request")
  // A held request is never dropped while the result side is stalled.
  `PIC_ASSERT_NEXT(a_inq_hold, inq_valid_r && !adv, inq_valid_r && $stable(inq_r), "held request lost")

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pic_regs_pkg::*;

  // Offsets that the package does not name.
  localparam logic [ADDR_W-1:0] OFF_STAT3  = 13'h203;
  localparam logic [ADDR_W-1:0] OFF_INSTAT = 13'h206;

  // Power-on priority levels, source 0 first.
  localparam logic [LVL_W-1:0] LEVEL_AT_RESET [0:14] = '{
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd4,
    3'd2, 3'd2, 3'd0, 3'd1, 3'd3, 3'd1, 3'd7
  };

  localparam int RANDOM_REQUESTS = 1750;
  localparam int IDLE_LIMIT      = 1000;
  localparam int DRAIN_CYCLES    = 8;

  // One request as it waits in the backlog. The gap is the number of idle
  // cycles the sender inserts before presenting it. A request marked as a
  // drain point is held back until every outstanding result has come home.
  typedef struct {
    pic_req_t    req;
    int unsigned gap;
    bit          drain;
  } queued_request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_mode = 2'd0;
  logic [ADDR_W-1:0]     in_address = '0;
  logic [DATA_W-1:0]     in_write_data = '0;
  logic [MASK_W-1:0]     in_source_mask = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DATA_W-1:0]     out_read_data;
  logic                  out_irq_notify;
  logic                  out_control_strobe;
  logic [DATA_W-1:0]     out_control_value;
  logic [PEND_OUT_W-1:0] out_pending_sources;
  logic [LVL_W-1:0]      out_highest_level;

  queued_request_t request_backlog[$];
  pic_res_t        due_results[$];

  // Shadow copy of the controller's register file. Only the driver touches it.
  logic [LVL_W-1:0]       src_level [0:NUM_SOURCES-1];
  logic [NUM_SOURCES-1:0] pend_bits;
  logic [DATA_W-1:0]      rom_ctl;
  logic [DATA_W-1:0]      cnt_ctl;
  logic [CNT_W-1:0]       free_cnt;

  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned error_count = 0;
  int unsigned counter_reads = 0;
  int unsigned rom_writes = 0;
  int unsigned notify_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned idle_run = 0;
  int unsigned stall_left = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  priority_interrupt_controller_regs_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .in_source_mask      (in_source_mask),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_irq_notify      (out_irq_notify),
    .out_control_strobe  (out_control_strobe),
    .out_control_value   (out_control_value),
    .out_pending_sources (out_pending_sources),
    .out_highest_level   (out_highest_level)
  );

  always #5 clk = ~clk;

  // Applies one request to the shadow register file and returns the result the
  // controller must produce for it. Notify is raised for every level write to
  // a source other than the 60Hz one and for a ROM-control write; in every
  // other case it simply tracks whether the pending mask changed.
  function automatic pic_res_t execute_request(input pic_req_t rq);
    pic_res_t               r;
    logic [NUM_SOURCES-1:0] pend_was;
    logic [31:0]            lane_mask;
    int unsigned            lane;
    int unsigned            idx;
    r = '0;
    pend_was = pend_bits;
    case (rq.mode)
      MODE_READ: begin
        if (rq.address < NUM_SOURCES) begin
          r.read_data = DATA_W'(src_level[rq.address]);
        end else if (rq.address >= OFF_STAT0 && rq.address <= OFF_STAT3) begin
          // The pending mask reads back as a big-endian 32-bit word.
          lane = 32'(rq.address - OFF_STAT0);
          r.read_data = DATA_W'({17'b0, pend_bits} >> ((3 - lane) * 8));
        end else if (rq.address == OFF_ROMCTL) begin
          r.read_data = rom_ctl;
        end else if (rq.address == OFF_CNTCTL) begin
          r.read_data = cnt_ctl;
        end else if (rq.address == OFF_ACK60) begin
          // Reading the 60Hz acknowledge clears that source and returns zero.
          pend_bits[SRC_60HZ] = 1'b0;
        end else if (rq.address >= OFF_COUNT && rq.address < OFF_COUNT + 8) begin
          // The byte comes from the value before the read; the counter then
          // steps unless control bit 0 freezes it.
          idx = 32'(rq.address - OFF_COUNT);
          r.read_data = DATA_W'(free_cnt >> ((7 - idx) * 8));
          if (!cnt_ctl[0]) free_cnt = free_cnt + CNT_W'(1);
        end
      end
      MODE_WRITE: begin
        if (rq.address < NUM_SOURCES) begin
          src_level[rq.address] = rq.write_data[LVL_W-1:0];
          // A level write to the 60Hz source sets or clears that source.
          if (rq.address == SRC_60HZ) begin
            pend_bits[SRC_60HZ] = (rq.write_data[LVL_W-1:0] != '0);
          end else begin
            r.irq_notify = 1'b1;
          end
        end else if (rq.address >= OFF_STAT0 && rq.address <= OFF_STAT3) begin
          // Each written one clears the pending bit under it in that lane;
          // the two upper lanes hold no sources.
          lane = 32'(rq.address - OFF_STAT0);
          lane_mask = {24'b0, rq.write_data} << ((3 - lane) * 8);
          pend_bits = pend_bits & ~lane_mask[NUM_SOURCES-1:0];
        end else if (rq.address == OFF_ROMCTL) begin
          rom_ctl = rq.write_data;
          r.control_strobe = 1'b1;
          r.irq_notify = 1'b1;
        end else if (rq.address == OFF_CNTCTL) begin
          cnt_ctl = rq.write_data;
        end else if (rq.address == OFF_ACK60) begin
          pend_bits[SRC_60HZ] = 1'b0;
        end
      end
      MODE_SET: begin
        pend_bits = pend_bits | rq.source_mask;
      end
      default: begin
        pend_bits = pend_bits & ~rq.source_mask;
      end
    endcase
    if (pend_bits != pend_was) r.irq_notify = 1'b1;
    r.control_value = rom_ctl;
    r.pending_sources = pend_bits;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (pend_bits[i] && src_level[i] > r.highest_level) r.highest_level = src_level[i];
    end
    return r;
  endfunction

  // Appends one request to the backlog with a random lead-in gap. The sender
  // now and then switches into a calm stretch where it never idles.
  task automatic queue_request(input mode_t m, input logic [ADDR_W-1:0] a,
                               input logic [DATA_W-1:0] d, input logic [MASK_W-1:0] sm,
                               input bit drain);
    queued_request_t q;
    q.req.mode = m;
    q.req.address = a;
    q.req.write_data = d;
    q.req.source_mask = sm;
    q.drain = drain;
    if ($urandom_range(0, 79) == 0) send_calm = !send_calm;
    q.gap = send_calm ? 0 : $urandom_range(0, 6);
    request_backlog.push_back(q);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10) begin
        $display("result %0d, %s: expected 0x%0h, got 0x%0h",
                 checked_count, name, want, got);
      end
    end
  endtask

  // Driver. A request counts as sent at the edge where in_valid is high and
  // in_stall is low; the expected result is computed right then from the
  // values on the ports. The next request goes out once its gap has elapsed,
  // and a drain point waits for the result queue to run dry first.
  always @(posedge clk) begin : driver
    pic_req_t rq;
    pic_res_t res;
    logic     fired;
    logic     load;
    fired = in_valid && !in_stall;
    load = 1'b0;
    if (!rst_n) begin
      foreach (src_level[i]) src_level[i] = LEVEL_AT_RESET[i];
      pend_bits = '0;
      rom_ctl = ROM_CTL_RST;
      cnt_ctl = '0;
      free_cnt = '0;
      idle_run = 0;
      in_valid <= 1'b0;
    end else begin
      if (fired) begin
        rq.mode = mode_t'(in_mode);
        rq.address = in_address;
        rq.write_data = in_write_data;
        rq.source_mask = in_source_mask;
        res = execute_request(rq);
        due_results.push_back(res);
        sent_count++;
        if (res.irq_notify) notify_count++;
        if (res.control_strobe) rom_writes++;
        if (rq.mode == MODE_READ && rq.address >= OFF_COUNT && rq.address < OFF_COUNT + 8) begin
          counter_reads++;
        end
        idle_run = 0;
      end
      if (!in_valid || fired) begin
        if (request_backlog.size() != 0 && idle_run >= request_backlog[0].gap &&
            !(request_backlog[0].drain && due_results.size() != 0)) begin
          load = 1'b1;
        end else begin
          idle_run++;
        end
        if (load) begin
          in_mode <= request_backlog[0].req.mode;
          in_address <= request_backlog[0].req.address;
          in_write_data <= request_backlog[0].req.write_data;
          in_source_mask <= request_backlog[0].req.source_mask;
          void'(request_backlog.pop_front());
        end
        in_valid <= load;
      end
    end
  end

  // Monitor. Every accepted result is checked field by field against the
  // oldest expectation. After each result the receiver draws a random stall,
  // except in calm stretches where it never stalls.
  always @(posedge clk) begin : monitor
    pic_res_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("result with no request outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("read_data", 32'(want.read_data), 32'(out_read_data));
          check_field("irq_notify", 32'(want.irq_notify), 32'(out_irq_notify));
          check_field("control_strobe", 32'(want.control_strobe),
                      32'(out_control_strobe));
          check_field("control_value", 32'(want.control_value),
                      32'(out_control_value));
          check_field("pending_sources", 32'(want.pending_sources),
                      32'(out_pending_sources));
          check_field("highest_level", 32'(want.highest_level),
                      32'(out_highest_level));
        end
        checked_count++;
        if ($urandom_range(0, 79) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: a run that accepts nothing on either side for too long is hung.
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles", IDLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] a;
    logic [MASK_W-1:0] sm;
    int unsigned       pick;

    // Directed opening: level reads at both ends and just past the last source.
    queue_request(MODE_READ, 13'h000, 8'hff, 15'h7fff, 1'b0);
    queue_request(MODE_READ, 13'h00e, 8'h00, 15'h0000, 1'b0);
    queue_request(MODE_READ, 13'h00f, 8'h00, 15'h0000, 1'b0);
    // Every source pending, then the mask seen through status lanes two, three and zero.
    queue_request(MODE_SET, 13'h000, 8'h00, 15'h7fff, 1'b0);
    queue_request(MODE_READ, OFF_STAT0 + 13'd2, 8'h00, 15'h0000, 1'b0);
    queue_request(MODE_READ, OFF_STAT3, 8'h00, 15'h0000, 1'b0);
    queue_request(MODE_READ, OFF_STAT0, 8'h00, 15'h0000, 1'b0);
    // The 60Hz level: clear it, write zero again with high bits set, set it.
    queue_request(MODE_WRITE, 13'(SRC_60HZ), 8'h00, 15'h0000, 1'b0);
    queue_request(MODE_WRITE, 13'(SRC_60HZ), 8'hf8, 15'h0000, 1'b0);
    queue_request(MODE_WRITE, 13'(SRC_60HZ), 8'h05, 15'h0000, 1'b0);
    // The 60Hz acknowledge by write and, after setting it again, by read.
    queue_request(MODE_WRITE, OFF_ACK60, 8'h00, 15'h0000, 1'b0);
    queue_request(MODE_SET, 13'h000, 8'h00, 15'h0400, 1'b0);
    queue_request(MODE_READ, OFF_ACK60, 8'h00, 15'h0000, 1'b0);
    // Drop the top source's level so the highest level falls.
    queue_request(MODE_WRITE, 13'h00e, 8'hf8, 15'h0000, 1'b0);
    // Status lane clears, including an upper lane that holds nothing.
    queue_request(MODE_WRITE, OFF_STAT3, 8'hff, 15'h0000, 1'b0);
    queue_request(MODE_WRITE, OFF_STAT0 + 13'd1, 8'hff, 15'h0000, 1'b0);
    queue_request(MODE_WRITE, OFF_STAT0 + 13'd2, 8'hff, 15'h0000, 1'b0);
    // ROM control write and readback.
    queue_request(MODE_WRITE, OFF_ROMCTL, 8'ha5, 15'h0000, 1'b0);
    queue_request(MODE_READ, OFF_ROMCTL, 8'h00, 15'h0000, 1'b0);
    // Counter frozen, then running; the frozen read waits for an empty pipe.
    queue_request(MODE_WRITE, OFF_CNTCTL, 8'h01, 15'h0000, 1'b0);
    queue_request(MODE_READ, OFF_COUNT + 13'd7, 8'h00, 15'h0000, 1'b1);
    queue_request(MODE_WRITE, OFF_CNTCTL, 8'hfe, 15'h0000, 1'b0);
    queue_request(MODE_READ, OFF_COUNT + 13'd7, 8'h00, 15'h0000, 1'b0);
    queue_request(MODE_READ, OFF_CNTCTL, 8'h00, 15'h0000, 1'b0);
    // Writes that must be ignored, and the top of the address window.
    queue_request(MODE_WRITE, OFF_COUNT + 13'd7, 8'hff, 15'h0000, 1'b0);
    queue_request(MODE_WRITE, OFF_INSTAT, 8'hff, 15'h0000, 1'b0);
    queue_request(MODE_READ, OFF_INSTAT, 8'h00, 15'h0000, 1'b0);
    queue_request(MODE_WRITE, 13'h1fff, 8'h55, 15'h0000, 1'b0);
    queue_request(MODE_READ, 13'h1fff, 8'h00, 15'h0000, 1'b0);
    queue_request(MODE_CLEAR, 13'h000, 8'h00, 15'h7fff, 1'b0);

    // Random part. Most accesses land on the mapped registers; some hit the
    // whole window or the same low offsets with the upper address bits set.
    // Set masks are mostly sparse so pending stays partly populated.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: a = 13'($urandom_range(0, 15));
        3, 4, 5: a = OFF_STAT0 + 13'($urandom_range(0, 7));
        6, 7:    a = OFF_COUNT + 13'($urandom_range(0, 7));
        8:       a = 13'($urandom_range(0, 8191));
        default: a = (13'($urandom_range(0, 15)) << 9) | 13'($urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        sm = 15'($urandom);
      end else begin
        sm = 15'($urandom & $urandom & $urandom);
      end
      pick = $urandom_range(0, 99);
      queue_request(pick < 35 ? MODE_READ : pick < 65 ? MODE_WRITE :
                    pick < 85 ? MODE_SET : MODE_CLEAR,
                    a, 8'($urandom), sm, (n % 350) == 175);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (request_backlog.size() != 0 || in_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results.", sent_count, checked_count);
    $display("Covered %0d counter reads, %0d ROM-control writes, %0d notifications.",
             counter_reads, rom_writes, notify_count);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d failures", error_count);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
